// ===== rtl/vertex_project_and_backface_cull_core_assert.svh =====
// assertion macros for the vertex projection core
`ifndef VERTEX_PROJECT_AND_BACKFACE_CULL_CORE_ASSERT_SVH
`define VERTEX_PROJECT_AND_BACKFACE_CULL_CORE_ASSERT_SVH
// implication checked at every clock edge outside reset
`define VPC_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked at every clock edge outside reset
`define VPC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== rtl/vpc_pkg.sv =====
// shared types and constants for the vertex projection core
package vpc_pkg;
  localparam int unsigned MaxVertices  = 256;
  localparam int unsigned ScreenWidth  = 128;
  localparam int unsigned ScreenHeight = 64;
  localparam int unsigned NumCfgRegs   = 8;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  localparam logic REQ_VERTEX   = 1'b0;
  localparam logic REQ_TRIANGLE = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic        [7:0]  vertex_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [7:0]  corner_a;
    logic        [7:0]  corner_b;
    logic        [7:0]  corner_c;
  } req_t;

  typedef struct packed {
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] c_x;
    logic signed [15:0] c_y;
  } res_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ===== rtl/vpc_divider.sv =====
// iterative signed divider, one quotient bit a cycle, truncating toward zero
module vpc_divider #(
  parameter int unsigned Width = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [Width-1:0] num_i,
  input  logic signed [Width-1:0] den_i,
  output vpc_pkg::div_ctl_t       ctl_o,
  output logic signed [Width-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic             neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width:0]   trial;
  logic [Width-1:0] num_abs, den_abs;

  assign num_abs = num_i[Width-1] ? Width'(-num_i) : num_i;
  assign den_abs = den_i[Width-1] ? Width'(-den_i) : den_i;
  assign trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = '0;
      quo_d  = num_abs;
      den_d  = den_abs;
      neg_d  = num_i[Width-1] ^ den_i[Width-1];
      busy_d = 1'b1;
      cnt_d  = CntW'(Width);
    end else if (busy_q) begin
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quo_o = neg_q ? Width'(-quo_q) : quo_q;
endmodule

// ===== rtl/vertex_project_and_backface_cull_core.sv =====
// top level: vertex projection to screen store and triangle back-face cull
//
// channel  | handshake          | payload
// request  | start / busy       | req_i   (vpc_pkg::req_t)
// result   | res_valid_o        | res_o   (vpc_pkg::res_t)
// config   | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// a vertex keeps busy high through the multiply steps (12 products through one
// 32x32 multiplier), then x and y each take a start state and a wait in the 64-bit
// bit-serial divider, then one store write; both divides are skipped when w is zero
// a triangle keeps busy high through three store reads, area and emit;
// the result strobe rises as busy drops, only for a non-negative area, and cannot be stalled
// reset clears control state and the matrix; the point store is undefined until written
module vertex_project_and_backface_cull_core #(
  parameter int unsigned MaxVertices  = vpc_pkg::MaxVertices,
  parameter int unsigned ScreenWidth  = vpc_pkg::ScreenWidth,
  parameter int unsigned ScreenHeight = vpc_pkg::ScreenHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  vpc_pkg::req_t                 req_i,
  output logic                          res_valid_o,
  output vpc_pkg::res_t                 res_o,
  input  logic                          cfg_we_i,
  input  logic [vpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vpc_pkg::CfgDataW-1:0]  cfg_data_i
);
  localparam int unsigned AddrW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned AccW  = 49;
  localparam int unsigned SumW  = AccW + 1;
  localparam int unsigned DivW  = 64;
  localparam logic signed [DivW-1:0] HalfW = DivW'(ScreenWidth / 2);
  localparam logic signed [DivW-1:0] HalfH = DivW'(ScreenHeight / 2);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL   = 10'b0000000010,
    ST_DIVX  = 10'b0000000100,
    ST_WAITX = 10'b0000001000,
    ST_DIVY  = 10'b0000010000,
    ST_WAITY = 10'b0000100000,
    ST_WRITE = 10'b0001000000,
    ST_READ  = 10'b0010000000,
    ST_AREA  = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [vpc_pkg::CfgDataW-1:0] cfg_q [vpc_pkg::NumCfgRegs];
  logic signed [15:0] xmem [MaxVertices];
  logic signed [15:0] ymem [MaxVertices];

  vpc_pkg::req_t      req_q;
  logic [3:0]         step_q;           // multiply step: row (0,1,3) x col
  logic signed [AccW-1:0] acc_x_q, acc_y_q, acc_w_q;
  logic signed [63:0] prod_q;
  logic [3:0]         pstep_q;
  logic               pvalid_q;
  logic signed [15:0] sx_q;
  logic signed [15:0] sy_q;
  logic signed [15:0] px_q [3];
  logic signed [15:0] py_q [3];
  logic [1:0]         rd_cnt_q;
  logic [2:0]         rd_vld_q;         // corner in range, per read
  logic               rd_pend_q;
  logic [1:0]         rd_slot_q;
  logic signed [15:0] rd_x_q, rd_y_q;
  logic signed [33:0] t1_q, t2_q;
  vpc_pkg::res_t      res_q;
  logic               res_valid_q;

  // divider
  vpc_pkg::div_ctl_t  div_ctl;
  logic               div_start;
  logic signed [DivW-1:0] div_num, div_den, div_quo;

  vpc_divider #(.Width(DivW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .ctl_o   (div_ctl),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(vpc_pkg::NumCfgRegs); i++) cfg_q[i] <= '0;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // multiply step: row index from step, columns 0..3
  logic [1:0]         m_row, m_col;
  logic [2:0]         m_ridx;
  logic signed [31:0] m_coef, m_coord;
  logic [vpc_pkg::CfgDataW-1:0] m_reg;
  assign m_row  = (step_q[3:2] == 2'd2) ? 2'd3 : step_q[3:2];
  assign m_col  = step_q[1:0];
  assign m_ridx = {m_row, m_col[1]};
  assign m_reg  = cfg_q[m_ridx];
  assign m_coef = m_col[0] ? m_reg[31:0] : m_reg[63:32];
  always_comb begin
    case (m_col)
      2'd0:    m_coord = req_q.pos_x;
      2'd1:    m_coord = req_q.pos_y;
      2'd2:    m_coord = req_q.pos_z;
      default: m_coord = 32'sd65536;     // constant term times one
    endcase
  end

  logic signed [AccW-1:0] term;
  assign term = AccW'(prod_q >>> 16);    // arithmetic shift floors

  // screen mapping: num = half*(v+w), den = w
  logic signed [AccW-1:0] v_sel;
  logic signed [SumW-1:0] vw_sum;
  logic signed [DivW-1:0] half_sel;
  logic               is_y;
  assign is_y     = (state_q == ST_DIVY) || (state_q == ST_WAITY);
  assign v_sel    = is_y ? acc_y_q : acc_x_q;
  assign half_sel = is_y ? HalfH : HalfW;
  assign vw_sum   = SumW'(v_sel) + SumW'(acc_w_q);
  assign div_num  = half_sel * DivW'(vw_sum);
  assign div_den  = DivW'(acc_w_q);
  assign div_start = ((state_q == ST_DIVX) || (state_q == ST_DIVY)) && (acc_w_q != 0);

  function automatic logic signed [15:0] sat16(input logic signed [DivW-1:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  logic signed [15:0] wz_val;
  assign wz_val = (v_sel > 0) ? 16'sh7fff :
                  (v_sel < 0) ? -16'sh8000 : sat16(half_sel);

  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_idx;
  always_comb begin
    case (rd_cnt_q)
      2'd0:    rd_idx = req_q.corner_a;
      2'd1:    rd_idx = req_q.corner_b;
      default: rd_idx = req_q.corner_c;
    endcase
  end
  assign rd_addr = AddrW'(rd_idx);

  logic signed [33:0] area;
  assign area = t1_q - t2_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = (req_i.req_type == vpc_pkg::REQ_TRIANGLE) ? ST_READ : ST_MUL;
      ST_MUL:   if (pvalid_q && pstep_q == 4'd11) state_d = ST_DIVX;
      ST_DIVX:  state_d = (acc_w_q == 0) ? ST_DIVY : ST_WAITX;
      ST_WAITX: if (div_ctl.done) state_d = ST_DIVY;
      ST_DIVY:  state_d = (acc_w_q == 0) ? ST_WRITE : ST_WAITY;
      ST_WAITY: if (div_ctl.done) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      ST_READ:  if (rd_pend_q && rd_slot_q == 2'd2) state_d = ST_AREA;
      ST_AREA:  state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pvalid_q    <= 1'b0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      pvalid_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      if (state_q == ST_IDLE) begin
        step_q   <= '0;
        rd_cnt_q <= '0;
      end
      if (state_q == ST_MUL && step_q != 4'd12) begin
        pvalid_q <= 1'b1;
        step_q   <= step_q + 1'b1;
      end
      if (state_q == ST_READ && rd_cnt_q != 2'd3) begin
        rd_pend_q <= 1'b1;
        rd_cnt_q  <= rd_cnt_q + 1'b1;
      end
      if (state_q == ST_EMIT) res_valid_q <= !area[33];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      req_q   <= req_i;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_w_q <= '0;
    end
    prod_q  <= m_coef * m_coord;
    pstep_q <= step_q;
    if (pvalid_q) begin
      case (pstep_q[3:2])
        2'd0:    acc_x_q <= acc_x_q + term;
        2'd1:    acc_y_q <= acc_y_q + term;
        default: acc_w_q <= acc_w_q + term;
      endcase
    end
    if (state_q == ST_DIVX && acc_w_q == 0) sx_q <= wz_val;
    if (state_q == ST_WAITX && div_ctl.done) sx_q <= sat16(div_quo);
    if (state_q == ST_DIVY && acc_w_q == 0) sy_q <= wz_val;
    if (state_q == ST_WAITY && div_ctl.done) sy_q <= sat16(div_quo);
    // point store: one write port, one registered read port
    if (state_q == ST_WRITE && 32'(req_q.vertex_slot) < MaxVertices) begin
      xmem[AddrW'(req_q.vertex_slot)] <= sx_q;
      ymem[AddrW'(req_q.vertex_slot)] <= sy_q;
    end
    rd_x_q    <= xmem[rd_addr];
    rd_y_q    <= ymem[rd_addr];
    rd_slot_q <= rd_cnt_q;
    if (state_q == ST_READ && rd_cnt_q != 2'd3) begin
      rd_vld_q[rd_cnt_q] <= 32'(rd_idx) < MaxVertices;
    end
    if (rd_pend_q) begin
      px_q[rd_slot_q] <= rd_vld_q[rd_slot_q] ? rd_x_q : 16'sd0;
      py_q[rd_slot_q] <= rd_vld_q[rd_slot_q] ? rd_y_q : 16'sd0;
    end
    if (state_q == ST_AREA) begin
      t1_q <= 34'((px_q[0] - px_q[1]) * (py_q[2] - py_q[1]));
      t2_q <= 34'((py_q[0] - py_q[1]) * (px_q[2] - px_q[1]));
    end
    if (state_q == ST_EMIT) begin
      res_q.a_x <= px_q[0];
      res_q.a_y <= py_q[0];
      res_q.b_x <= px_q[1];
      res_q.b_y <= py_q[1];
      res_q.c_x <= px_q[2];
      res_q.c_y <= py_q[2];
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

// ===== rtl/vpc_checker.sv =====
// port-level checker for the vertex projection core
`include "vertex_project_and_backface_cull_core_assert.svh"
module vpc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input vpc_pkg::req_t req_i,
  input logic          res_valid_o
);
  `VPC_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start && !busy, busy, "busy not raised")
  `VPC_ASSERT_NEXT(a_one_strobe, clk_i, rst_ni, res_valid_o, !res_valid_o, "strobe held")
  `VPC_ASSERT_IMP(a_strobe_when_busy, clk_i, rst_ni, res_valid_o, !busy, "strobe while busy")
  `VPC_ASSERT_NEXT(a_vertex_no_res, clk_i, rst_ni,
    start && !busy && req_i.req_type == vpc_pkg::REQ_VERTEX, !res_valid_o, "vertex result")
endmodule

bind vertex_project_and_backface_cull_core vpc_checker u_vpc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .req_i(req_i), .res_valid_o(res_valid_o)
);
